>>> hw/rtl/sfe_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame encoder.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package sfe_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam int          QDEPTH   = 2;
  localparam int          QPTR_W   = $clog2(QDEPTH);
  localparam int          QCNT_W   = $clog2(QDEPTH + 1);

  // input kinds carried on tuser
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  // header and trailer byte positions of a start command
  localparam logic [3:0] ST_SOF0    = 4'd0;
  localparam logic [3:0] ST_SOF1    = 4'd1;
  localparam logic [3:0] ST_VER     = 4'd2;
  localparam logic [3:0] ST_TYPE    = 4'd3;
  localparam logic [3:0] ST_FLAGS   = 4'd4;
  localparam logic [3:0] ST_SEQ_LO  = 4'd5;
  localparam logic [3:0] ST_SEQ_HI  = 4'd6;
  localparam logic [3:0] ST_LEN_LO  = 4'd7;
  localparam logic [3:0] ST_LEN_HI  = 4'd8;
  localparam logic [3:0] ST_CRC_LO  = 4'd9;
  localparam logic [3:0] ST_CRC_HI  = 4'd10;
  // positions of a payload command
  localparam logic [3:0] PL_DATA    = 4'd0;
  localparam logic [3:0] PL_CRC_LO  = 4'd1;
  localparam logic [3:0] PL_CRC_HI  = 4'd2;

  // register indexes
  localparam logic [1:0] REG_SOF_FIRST  = 2'd0;
  localparam logic [1:0] REG_SOF_SECOND = 2'd1;
  localparam logic [1:0] REG_VERSION    = 2'd2;

  typedef struct packed {
    logic        kind;       // REQ_START or REQ_PAYLOAD
    logic        close;      // CRC trailer follows this command
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [15:0] seq;
    logic [15:0] len;
    logic [7:0]  data;
  } sfe_cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } sfe_q_status_t;

  typedef struct packed {
    logic [7:0] sof_first;
    logic [7:0] sof_second;
    logic [7:0] version;
  } sfe_cfg_t;

  // one byte through CRC-16/CCITT-FALSE, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sfe_front.sv
// Front end: accepts input words, tracks frame state and drops misplaced words.
// Uses sfe_pkg; pushes classified commands into sfe_queue.
`default_nettype none
module sfe_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  wire                   in_kind,
  input  wire [55:0]            in_data,
  input  sfe_pkg::sfe_q_status_t q_status,
  output logic                  in_ready,
  output logic                  push,
  output sfe_pkg::sfe_cmd_t     push_cmd
);

  logic        open_r, open_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic        accept;
  logic [15:0] len;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign len      = in_data[47:32];

  always_comb begin
    open_nxt              = open_r;
    rem_nxt               = rem_r;
    push                  = 1'b0;
    push_cmd.kind         = in_kind;
    push_cmd.close        = 1'b0;
    push_cmd.frame_type   = in_data[7:0];
    push_cmd.frame_flags  = in_data[15:8];
    push_cmd.seq          = in_data[31:16];
    push_cmd.len          = len;
    push_cmd.data         = in_data[55:48];
    if (accept) begin
      if (in_kind == sfe_pkg::REQ_START) begin
        if (!open_r) begin
          push           = 1'b1;
          push_cmd.close = (len == 16'd0);
          if (len != 16'd0) begin
            open_nxt = 1'b1;
            rem_nxt  = len;
          end
        end
      end else if (open_r) begin
        push           = 1'b1;
        push_cmd.close = (rem_r == 16'd1);
        rem_nxt        = rem_r - 16'd1;
        if (rem_r == 16'd1) begin
          open_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      rem_r  <= 16'd0;
    end else begin
      open_r <= open_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sfe_queue.sv
// Two-entry command queue between front and back end.
// Uses sfe_pkg for the command type and depth.
`default_nettype none
module sfe_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  sfe_pkg::sfe_cmd_t      push_cmd,
  input  wire                    pop,
  output sfe_pkg::sfe_cmd_t      head,
  output sfe_pkg::sfe_q_status_t status
);

  sfe_pkg::sfe_cmd_t               mem_r [sfe_pkg::QDEPTH];
  logic [sfe_pkg::QPTR_W-1:0]      wr_r, rd_r;
  logic [sfe_pkg::QCNT_W-1:0]      cnt_r;
  logic                            do_pop;

  assign head             = mem_r[rd_r];
  assign status.full      = (cnt_r == sfe_pkg::QCNT_W'(sfe_pkg::QDEPTH));
  assign status.not_empty = (cnt_r != '0);
  assign do_pop           = pop && status.not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == sfe_pkg::QPTR_W'(sfe_pkg::QDEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == sfe_pkg::QPTR_W'(sfe_pkg::QDEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sfe_back.sv
// Back end: expands queued commands into frame bytes, runs the CRC and
// drives the registered output word. Uses sfe_pkg (types, crc_feed).
`default_nettype none
module sfe_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  sfe_pkg::sfe_cfg_t      cfg,
  input  sfe_pkg::sfe_cmd_t      head,
  input  sfe_pkg::sfe_q_status_t q_status,
  output logic                   pop,
  input  wire                    out_ready,
  output logic                   out_valid,
  output logic [7:0]             out_byte,
  output logic                   out_frame_end,
  output logic                   out_run_last
);

  logic [3:0]  step_r, step_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        end_r, end_nxt;
  logic        last_r, last_nxt;
  logic        load;
  logic [3:0]  last_step;
  logic [7:0]  sel_byte;
  logic        sel_end;
  logic        feed;
  logic [15:0] crc_base;

  assign load = q_status.not_empty && (!valid_r || out_ready);

  always_comb begin
    sel_byte = 8'h00;
    sel_end  = 1'b0;
    feed     = 1'b0;
    crc_base = crc_r;
    if (head.kind == sfe_pkg::REQ_START) begin
      last_step = head.close ? sfe_pkg::ST_CRC_HI : sfe_pkg::ST_LEN_HI;
      unique case (step_r)
        sfe_pkg::ST_SOF0:   sel_byte = cfg.sof_first;
        sfe_pkg::ST_SOF1:   sel_byte = cfg.sof_second;
        sfe_pkg::ST_VER: begin
          sel_byte = cfg.version;
          crc_base = sfe_pkg::CRC_INIT;
          feed     = 1'b1;
        end
        sfe_pkg::ST_TYPE: begin
          sel_byte = head.frame_type;
          feed     = 1'b1;
        end
        sfe_pkg::ST_FLAGS: begin
          sel_byte = head.frame_flags;
          feed     = 1'b1;
        end
        sfe_pkg::ST_SEQ_LO: begin
          sel_byte = head.seq[7:0];
          feed     = 1'b1;
        end
        sfe_pkg::ST_SEQ_HI: begin
          sel_byte = head.seq[15:8];
          feed     = 1'b1;
        end
        sfe_pkg::ST_LEN_LO: begin
          sel_byte = head.len[7:0];
          feed     = 1'b1;
        end
        sfe_pkg::ST_LEN_HI: begin
          sel_byte = head.len[15:8];
          feed     = 1'b1;
        end
        sfe_pkg::ST_CRC_LO: sel_byte = crc_r[7:0];
        sfe_pkg::ST_CRC_HI: begin
          sel_byte = crc_r[15:8];
          sel_end  = 1'b1;
        end
        default: sel_byte = 8'h00;
      endcase
    end else begin
      last_step = head.close ? sfe_pkg::PL_CRC_HI : sfe_pkg::PL_DATA;
      unique case (step_r)
        sfe_pkg::PL_DATA: begin
          sel_byte = head.data;
          feed     = 1'b1;
        end
        sfe_pkg::PL_CRC_LO: sel_byte = crc_r[7:0];
        sfe_pkg::PL_CRC_HI: begin
          sel_byte = crc_r[15:8];
          sel_end  = 1'b1;
        end
        default: sel_byte = 8'h00;
      endcase
    end
  end

  always_comb begin
    step_nxt  = step_r;
    crc_nxt   = crc_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    end_nxt   = end_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (valid_r && out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
      byte_nxt  = sel_byte;
      end_nxt   = sel_end;
      last_nxt  = (step_r == last_step);
      if (feed) begin
        crc_nxt = sfe_pkg::crc_feed(crc_base, sel_byte);
      end
      // retire the command on its final byte
      if (step_r == last_step) begin
        pop      = 1'b1;
        step_nxt = 4'd0;
      end else begin
        step_nxt = step_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 4'd0;
      crc_r   <= sfe_pkg::CRC_INIT;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      crc_r   <= crc_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    end_r  <= end_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_frame_end = end_r;
  assign out_run_last  = last_r;

endmodule
`default_nettype wire

>>> hw/rtl/serial_frame_encoder_crc16_top.sv
// Top level of the framed packet encoder with CRC-16/CCITT-FALSE.
// Holds the APB register bank; uses sfe_pkg, sfe_front, sfe_queue, sfe_back.
//
//   channel  direction  handshake              payload
//   in_      slave      in_tvalid/in_tready    tdata: type,flags,seq,len,data; tuser: kind
//   out_     master     out_tvalid/out_tready  tdata: byte; tuser: frame_end; tlast: run_last
//   cfg_     apb slave  psel/penable/pready    3 byte registers at 0x0, 0x4, 0x8
//
// One output word leaves per cycle while out_tready is high and a command is queued:
// a start word yields 9 bytes (11 with the CRC trailer), a payload word 1 (3 with the trailer).
// The front accepts one word per cycle while the two-entry command queue has room;
// dropped words are taken and cause nothing. Sync reset clears frame state,
// the CRC and registers; out_tready low holds the output word and fills the queue.
`default_nettype none
module serial_frame_encoder_crc16_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [55:0] in_tdata,   // [7:0] frame_type, [15:8] frame_flags,
                                  // [31:16] sequence_number, [47:32] body_length,
                                  // [55:48] data_byte
  input  wire         in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tuser,  // [0] frame_end
  output logic        out_tlast,  // run_last
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  sfe_pkg::sfe_cfg_t      cfg_r;
  sfe_pkg::sfe_q_status_t q_status;
  sfe_pkg::sfe_cmd_t      push_cmd;
  sfe_pkg::sfe_cmd_t      head;
  logic                   push;
  logic                   pop;
  logic                   wr_en;
  logic [1:0]             reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        sfe_pkg::REG_SOF_FIRST:  cfg_r.sof_first  <= cfg_pwdata[7:0];
        sfe_pkg::REG_SOF_SECOND: cfg_r.sof_second <= cfg_pwdata[7:0];
        sfe_pkg::REG_VERSION:    cfg_r.version    <= cfg_pwdata[7:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sfe_pkg::REG_SOF_FIRST:  cfg_prdata = {24'd0, cfg_r.sof_first};
      sfe_pkg::REG_SOF_SECOND: cfg_prdata = {24'd0, cfg_r.sof_second};
      sfe_pkg::REG_VERSION:    cfg_prdata = {24'd0, cfg_r.version};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  sfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .in_data  (in_tdata),
    .q_status (q_status),
    .in_ready (in_tready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  sfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  sfe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .head          (head),
    .q_status      (q_status),
    .pop           (pop),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_byte      (out_tdata),
    .out_frame_end (out_tuser),
    .out_run_last  (out_tlast)
  );

endmodule
`default_nettype wire
